### rtl/core/ctok_pkg.sv
`default_nettype none

package ctok_pkg;

  typedef enum logic [2:0] {
    MODE_NONE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_OPEN = 3'd3,
    MODE_STR  = 3'd4
  } run_mode_t;

  typedef enum logic [2:0] {
    KIND_STRING = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_WORD   = 3'd2,
    KIND_SPEC   = 3'd3,
    KIND_EOS    = 3'd4
  } token_kind_t;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_numeric(input logic [7:0] c);
    return is_digit(c) || (c == CH_DOT);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

### rtl/core/character_class_tokenizer_core.sv
`default_nettype none

// Channel  Direction  Handshake                Payload
// in_      input      in_valid / in_ready      in_action, in_char_code
// out_     output     out_valid / out_ready    out_token_char, out_char_kept,
//                                              out_token_start, out_token_kind,
//                                              out_unterminated
//
// One item per cycle sustained while out_ready stays high; an accepted item
// passes through the input register, then the result register, before it
// shows on the output.
// The run mode advances when an item moves from the input register into the
// result register, so items are classified strictly in order.
// Reset clears both valid flags and sets the mode to none (between tokens).
// A stalled output holds its item; once full, the input register refills only
// as the result register drains.

module character_class_tokenizer_core
  import ctok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [7:0] in_char_code,

  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_token_char,
  output logic            out_char_kept,
  output logic            out_token_start,
  output logic [2:0]      out_token_kind,
  output logic            out_unterminated
);

  logic        in_valid_r;
  logic        action_r;
  logic [7:0]  char_r;
  run_mode_t   mode_r, mode_nxt;

  logic        out_valid_r;
  logic [7:0]  token_char_r, token_char_nxt;
  logic        char_kept_r, char_kept_nxt;
  logic        token_start_r, token_start_nxt;
  token_kind_t token_kind_r, token_kind_nxt;
  logic        unterminated_r, unterminated_nxt;

  logic        advance;
  logic        in_string;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  assign in_string = (mode_r == MODE_OPEN) || (mode_r == MODE_STR);

  always_comb begin
    token_char_nxt   = char_r;
    char_kept_nxt    = 1'b0;
    token_start_nxt  = 1'b0;
    token_kind_nxt   = KIND_STRING;
    unterminated_nxt = 1'b0;
    mode_nxt         = mode_r;

    if (action_r == ACT_EOL) begin
      token_char_nxt   = 8'h00;
      token_start_nxt  = 1'b1;
      token_kind_nxt   = KIND_EOS;
      unterminated_nxt = in_string;
      mode_nxt         = MODE_NONE;
    end else if (in_string) begin
      // A quote right after the opening one still starts an (empty) token.
      token_start_nxt = (mode_r == MODE_OPEN);
      if (char_r == CH_QUOTE) begin
        mode_nxt = MODE_NONE;
      end else begin
        char_kept_nxt = 1'b1;
        mode_nxt      = MODE_STR;
      end
    end else if (is_space(char_r)) begin
      mode_nxt = MODE_NONE;
    end else if (char_r == CH_QUOTE) begin
      mode_nxt = MODE_OPEN;
    end else if ((mode_r == MODE_NUM) && is_numeric(char_r)) begin
      char_kept_nxt  = 1'b1;
      token_kind_nxt = KIND_NUMBER;
    end else if ((mode_r == MODE_WORD) && is_word(char_r)) begin
      char_kept_nxt  = 1'b1;
      token_kind_nxt = KIND_WORD;
    end else if (is_digit(char_r)) begin
      char_kept_nxt   = 1'b1;
      token_start_nxt = 1'b1;
      token_kind_nxt  = KIND_NUMBER;
      mode_nxt        = MODE_NUM;
    end else if (is_alpha(char_r) || (char_r == CH_UNDER)) begin
      char_kept_nxt   = 1'b1;
      token_start_nxt = 1'b1;
      token_kind_nxt  = KIND_WORD;
      mode_nxt        = MODE_WORD;
    end else begin
      char_kept_nxt   = 1'b1;
      token_start_nxt = 1'b1;
      token_kind_nxt  = KIND_SPEC;
      mode_nxt        = MODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_NONE;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          mode_r <= mode_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      action_r <= in_action;
      char_r   <= in_char_code;
    end
    if (advance && in_valid_r) begin
      token_char_r   <= token_char_nxt;
      char_kept_r    <= char_kept_nxt;
      token_start_r  <= token_start_nxt;
      token_kind_r   <= token_kind_nxt;
      unterminated_r <= unterminated_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_char   = token_char_r;
  assign out_char_kept    = char_kept_r;
  assign out_token_start  = token_start_r;
  assign out_token_kind   = token_kind_r;
  assign out_unterminated = unterminated_r;

endmodule

`default_nettype wire

### verif/tokenizer_checker.sv
`timescale 1ns / 100ps

module tokenizer_checker
  import ctok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic       in_action,
  input  wire logic [7:0] in_char_code,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_token_char,
  input  wire logic       out_char_kept,
  input  wire logic       out_token_start,
  input  wire logic [2:0] out_token_kind,
  input  wire logic       out_unterminated,
  output int              fail_count,
  output int              waiting,
  output int              checked
);

  typedef struct packed {
    logic [7:0]  ch;
    logic        kept;
    logic        start;
    token_kind_t kind;
    logic        unterm;
  } token_out_t;

  token_out_t token_q[$];
  token_out_t want_tok;
  token_out_t new_tok;
  run_mode_t  lex_mode;
  run_mode_t  lex_next;

  initial begin
    fail_count = 0;
    waiting    = 0;
    checked    = 0;
    lex_mode   = MODE_NONE;
  end

  // Classifies one item against the current run mode and gives the next mode.
  function automatic token_out_t classify(input logic act, input logic [7:0] c,
                                          input run_mode_t cur, output run_mode_t nxt);
    token_out_t r;
    logic       digit;
    logic       alpha;
    logic       in_str;
    digit  = (c >= 8'h30) && (c <= 8'h39);
    alpha  = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    in_str = (cur == MODE_OPEN) || (cur == MODE_STR);
    r = '{ch: c, kept: 1'b0, start: 1'b0, kind: KIND_STRING, unterm: 1'b0};
    nxt = cur;
    if (act == ACT_EOL) begin
      r.ch     = 8'h00;
      r.start  = 1'b1;
      r.kind   = KIND_EOS;
      r.unterm = in_str;
      nxt      = MODE_NONE;
    end else if (in_str) begin
      // A quote right after the opening one still starts an (empty) string token.
      r.start = (cur == MODE_OPEN);
      if (c == CH_QUOTE) begin
        nxt = MODE_NONE;
      end else begin
        r.kept = 1'b1;
        nxt    = MODE_STR;
      end
    end else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF)) begin
      nxt = MODE_NONE;
    end else if (c == CH_QUOTE) begin
      nxt = MODE_OPEN;
    end else if ((cur == MODE_NUM) && (digit || (c == CH_DOT))) begin
      r.kept = 1'b1;
      r.kind = KIND_NUMBER;
    end else if ((cur == MODE_WORD) && (alpha || digit || (c == CH_UNDER))) begin
      r.kept = 1'b1;
      r.kind = KIND_WORD;
    end else if (digit) begin
      r.kept  = 1'b1;
      r.start = 1'b1;
      r.kind  = KIND_NUMBER;
      nxt     = MODE_NUM;
    end else if (alpha || (c == CH_UNDER)) begin
      r.kept  = 1'b1;
      r.start = 1'b1;
      r.kind  = KIND_WORD;
      nxt     = MODE_WORD;
    end else begin
      r.kept  = 1'b1;
      r.start = 1'b1;
      r.kind  = KIND_SPEC;
      nxt     = MODE_NONE;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_mode = MODE_NONE;
      token_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        new_tok = classify(in_action, in_char_code, lex_mode, lex_next);
        lex_mode = lex_next;
        token_q.push_back(new_tok);
      end
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual char %0d kind %0d",
                   $time, out_token_char, out_token_kind);
          fail_count++;
        end else begin
          want_tok = token_q.pop_front();
          check_field("token_char", int'(want_tok.ch), int'(out_token_char));
          check_field("char_kept", int'(want_tok.kept), int'(out_char_kept));
          check_field("token_start", int'(want_tok.start), int'(out_token_start));
          check_field("token_kind", int'(want_tok.kind), int'(out_token_kind));
          check_field("unterminated", int'(want_tok.unterm), int'(out_unterminated));
          checked++;
        end
      end
    end
    waiting <= token_q.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import ctok_pkg::*;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_action    = ACT_CHAR;
  logic [7:0] in_char_code = 8'h00;
  logic       out_ready    = 1'b0;
  logic       calm         = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_token_char;
  logic       out_char_kept;
  logic       out_token_start;
  logic [2:0] out_token_kind;
  logic       out_unterminated;

  int fail_count;
  int waiting;
  int checked;
  int sent     = 0;
  int eol_sent = 0;

  // Corner items as {action, char}.
  logic [8:0] corner_items [] = '{
    {ACT_CHAR, 8'h00}, {ACT_CHAR, 8'hFF}, {ACT_EOL, 8'hFF},
    {ACT_CHAR, "x"}, {ACT_CHAR, CH_UNDER}, {ACT_CHAR, "9"}, {ACT_CHAR, CH_DOT},
    {ACT_CHAR, "7"}, {ACT_CHAR, CH_DOT}, {ACT_CHAR, "5"}, {ACT_CHAR, "Z"},
    {ACT_CHAR, CH_TAB}, {ACT_CHAR, CH_QUOTE}, {ACT_CHAR, CH_QUOTE},
    {ACT_CHAR, CH_QUOTE}, {ACT_CHAR, 8'h80}, {ACT_CHAR, CH_SPACE}, {ACT_CHAR, CH_QUOTE},
    {ACT_CHAR, CH_QUOTE}, {ACT_EOL, 8'h00}, {ACT_CHAR, CH_QUOTE}, {ACT_CHAR, "q"},
    {ACT_EOL, 8'h22}, {ACT_CHAR, "a"}, {ACT_CHAR, CH_CR}, {ACT_CHAR, CH_LF}, {ACT_EOL, 8'h00}
  };

  initial begin
    forever #6 clk = ~clk;
  end

  character_class_tokenizer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_char   (out_token_char),
    .out_char_kept    (out_char_kept),
    .out_token_start  (out_token_start),
    .out_token_kind   (out_token_kind),
    .out_unterminated (out_unterminated)
  );

  tokenizer_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_char   (out_token_char),
    .out_char_kept    (out_char_kept),
    .out_token_start  (out_token_start),
    .out_token_kind   (out_token_kind),
    .out_unterminated (out_unterminated),
    .fail_count       (fail_count),
    .waiting          (waiting),
    .checked          (checked)
  );

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
  end

  task automatic send_item(input logic act, input logic [7:0] c);
    while (!calm && ($urandom_range(99) < 6)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (act == ACT_EOL) eol_sent++;
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(1)) return 8'h41 + 8'($urandom_range(25));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // One source line: tokens with random content, then end of line.
  task automatic send_line();
    int         n;
    int         len;
    logic [7:0] c;
    logic       open_str;
    n = $urandom_range(1, 6);
    open_str = 1'b0;
    for (int i = 0; i < n; i++) begin
      // Zero separators leave tokens back to back.
      repeat ($urandom_range(0, 2)) send_item(ACT_CHAR, pick_space());
      len = $urandom_range(0, 6);
      case ($urandom_range(4))
        0: begin
          send_item(ACT_CHAR, $urandom_range(3) == 0 ? CH_UNDER : pick_letter());
          repeat (len) begin
            case ($urandom_range(3))
              0, 1: c = pick_letter();
              2:    c = pick_digit();
              default: c = CH_UNDER;
            endcase
            send_item(ACT_CHAR, c);
          end
        end
        1: begin
          send_item(ACT_CHAR, pick_digit());
          repeat (len) send_item(ACT_CHAR, $urandom_range(4) == 0 ? CH_DOT : pick_digit());
        end
        2: begin
          send_item(ACT_CHAR, CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            c = 8'($urandom_range(255));
            send_item(ACT_CHAR, (c == CH_QUOTE) ? 8'h21 : c);
          end
          if ((i == n - 1) && ($urandom_range(3) == 0)) open_str = 1'b1;
          else send_item(ACT_CHAR, CH_QUOTE);
        end
        3: begin
          do c = 8'($urandom_range(255));
          while (((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                 ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDER) || (c == CH_QUOTE) ||
                 (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF));
          send_item(ACT_CHAR, c);
        end
        default: send_item(ACT_CHAR, 8'($urandom_range(255)));
      endcase
    end
    if (!open_str) repeat ($urandom_range(0, 2)) send_item(ACT_CHAR, pick_space());
    send_item(ACT_EOL, 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_items[i]) send_item(corner_items[i][8], corner_items[i][7:0]);

    while (sent < 975) begin
      // Neither side idles through the middle of the random part.
      calm <= (sent >= 400) && (sent < 650);
      if ($urandom_range(99) < 80) send_line();
      else send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Covered %0d items (%0d end of line) and checked %0d results:", sent, eol_sent,
             checked);
    $display("corner characters plus random lines of words, numbers, strings and specials.");
    if ((fail_count == 0) && (waiting == 0)) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results still expected.", waiting);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ctok_pkg.sv
rtl/core/character_class_tokenizer_core.sv
verif/tokenizer_checker.sv
verif/tb.sv
